// File: hw/rtl/gic_pkg.sv
// Shared constants, register codes and channel payload types for the grouped interrupt controller.
package gic_pkg;

   // Geometry
   localparam int NUM_GROUPS         = 7;
   localparam int LINE_W             = 32;
   localparam int GROUP_IDX_W        = 3;
   localparam int SUMMARY_OUT0_SHIFT = 8;

   // Operation codes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Register select codes
   localparam logic [2:0] REG_TYPE     = 3'd0;
   localparam logic [2:0] REG_POLARITY = 3'd1;
   localparam logic [2:0] REG_ROUTE    = 3'd2;
   localparam logic [2:0] REG_ENABLE   = 3'd3;
   localparam logic [2:0] REG_CLEAR    = 3'd4;
   localparam logic [2:0] REG_MASK_O1  = 3'd5;
   localparam logic [2:0] REG_MASK_O0  = 3'd6;
   localparam logic [2:0] REG_SUMMARY  = 3'd7;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [GROUP_IDX_W-1:0] group_index;
      logic [2:0]             reg_select;
      logic [LINE_W-1:0]      write_data;
   } req_type;

   typedef struct packed {
      logic [LINE_W-1:0] read_data;
      logic              out0_request;
      logic              out1_request;
   } rsp_type;

endpackage

// File: hw/rtl/gic_core.sv
// Line state, pending logic and register file of the grouped interrupt controller.
module gic_core (
   input  logic             clock,
   input  logic             reset,
   input  gic_pkg::req_type item,
   input  logic             process,
   output gic_pkg::rsp_type result
);
   import gic_pkg::*;

   logic [LINE_W-1:0] edge_type_ff  [NUM_GROUPS];
   logic [LINE_W-1:0] edge_type_in  [NUM_GROUPS];
   logic [LINE_W-1:0] low_active_ff [NUM_GROUPS];
   logic [LINE_W-1:0] low_active_in [NUM_GROUPS];
   logic [LINE_W-1:0] route_out0_ff [NUM_GROUPS];
   logic [LINE_W-1:0] route_out0_in [NUM_GROUPS];
   logic [LINE_W-1:0] enable_ff     [NUM_GROUPS];
   logic [LINE_W-1:0] enable_in     [NUM_GROUPS];
   logic [LINE_W-1:0] pending_ff    [NUM_GROUPS];
   logic [LINE_W-1:0] pending_in    [NUM_GROUPS];
   logic [LINE_W-1:0] prev_level_ff [NUM_GROUPS];
   logic [LINE_W-1:0] prev_level_in [NUM_GROUPS];

   logic [GROUP_IDX_W-1:0] grp;
   logic                   grp_ok;
   logic [LINE_W-1:0]      now_act;
   logic [LINE_W-1:0]      before_act;
   logic [LINE_W-1:0]      summary;
   logic [LINE_W-1:0]      rd;
   logic                   req0;
   logic                   req1;

   assign grp    = item.group_index;
   assign grp_ok = {1'b0, grp} < (GROUP_IDX_W + 1)'(NUM_GROUPS);

   // Summary word over the current state: out1 groups low, out0 groups from bit 8
   always_comb begin
      summary = '0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
         summary[k] = |(pending_ff[k] & enable_ff[k] & ~route_out0_ff[k]);
         summary[k + SUMMARY_OUT0_SHIFT] = |(pending_ff[k] & enable_ff[k] & route_out0_ff[k]);
      end
   end

   // Next state and read data for the item in the input register
   always_comb begin
      edge_type_in  = edge_type_ff;
      low_active_in = low_active_ff;
      route_out0_in = route_out0_ff;
      enable_in     = enable_ff;
      pending_in    = pending_ff;
      prev_level_in = prev_level_ff;
      rd            = '0;
      now_act       = item.write_data ^ low_active_ff[grp];
      before_act    = prev_level_ff[grp] ^ low_active_ff[grp];

      unique case (item.opcode)
         OP_SAMPLE: begin
            if (process && grp_ok) begin
               // edge lines latch on inactive-to-active, level lines while active
               pending_in[grp] = pending_ff[grp]
                               | (now_act & ~before_act & edge_type_ff[grp])
                               | (now_act & ~edge_type_ff[grp]);
               prev_level_in[grp] = item.write_data;
            end
         end
         OP_WRITE: begin
            if (process && grp_ok) begin
               unique case (item.reg_select)
                  REG_TYPE:     edge_type_in[grp]  = item.write_data;
                  REG_POLARITY: low_active_in[grp] = item.write_data;
                  REG_ROUTE:    route_out0_in[grp] = item.write_data;
                  REG_ENABLE:   enable_in[grp]     = item.write_data;
                  REG_CLEAR:    pending_in[grp]    = pending_ff[grp] & ~item.write_data;
                  default: ;
               endcase
            end
         end
         OP_READ: begin
            if (item.reg_select == REG_SUMMARY) begin
               rd = summary;
            end else if (grp_ok) begin
               unique case (item.reg_select)
                  REG_TYPE:     rd = edge_type_ff[grp];
                  REG_POLARITY: rd = low_active_ff[grp];
                  REG_ROUTE:    rd = route_out0_ff[grp];
                  REG_ENABLE:   rd = enable_ff[grp];
                  REG_MASK_O1:  rd = pending_ff[grp] & enable_ff[grp] & ~route_out0_ff[grp];
                  REG_MASK_O0:  rd = pending_ff[grp] & enable_ff[grp] & route_out0_ff[grp];
                  default:      rd = '0;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Request outputs reflect the state after the item
   always_comb begin
      req0 = 1'b0;
      req1 = 1'b0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
         req0 = req0 | (|(pending_in[k] & enable_in[k] & route_out0_in[k]));
         req1 = req1 | (|(pending_in[k] & enable_in[k] & ~route_out0_in[k]));
      end
   end

   assign result.read_data    = rd;
   assign result.out0_request = req0;
   assign result.out1_request = req1;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_GROUPS; k++) begin
            edge_type_ff[k]  <= '0;
            low_active_ff[k] <= '0;
            route_out0_ff[k] <= '0;
            enable_ff[k]     <= '0;
            pending_ff[k]    <= '0;
            prev_level_ff[k] <= '0;
         end
      end else begin
         edge_type_ff  <= edge_type_in;
         low_active_ff <= low_active_in;
         route_out0_ff <= route_out0_in;
         enable_ff     <= enable_in;
         pending_ff    <= pending_in;
         prev_level_ff <= prev_level_in;
      end
   end

endmodule

// File: hw/rtl/grouped_interrupt_controller_top.sv
// An accepted request transfer passes the input register, then the response register, to rsp_data.
// Throughput: one request per cycle; the input register and the response register
// decouple the two channels, so a held response stalls the input only when both are full.
// The state update and read happen in the single logic pass between the two registers.
// Reset (synchronous): all line configuration, pending bits and stored levels clear
// to zero, all lines masked; both pipeline registers empty.
module grouped_interrupt_controller_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gic_pkg::rsp_type rsp_data
);
   import gic_pkg::*;

   req_type stage_ff;
   req_type stage_in;
   logic    stage_valid_ff;
   logic    stage_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type core_result;
   logic    process;
   logic    accept;

   // Handshake: the staged item moves on when the response slot is free or draining
   assign process   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !process;
   assign accept    = req_valid && !req_stall;

   assign stage_in       = accept ? req_data : stage_ff;
   assign stage_valid_in = accept || (stage_valid_ff && !process);
   assign rsp_in         = process ? core_result : rsp_ff;
   assign rsp_valid_in   = process || (rsp_valid_ff && rsp_stall);

   gic_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (stage_ff),
      .process (process),
      .result  (core_result)
   );

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the grouped interrupt controller top level.
`timescale 1ns / 1ps

module testbench;
   import gic_pkg::*;

   // Opcode 3 has no name in the package; it must do nothing
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles to let pass after the last response before ending a phase
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   grouped_interrupt_controller_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Model state of the controller
   logic [LINE_W-1:0] line_edge_type [NUM_GROUPS];
   logic [LINE_W-1:0] line_low_active [NUM_GROUPS];
   logic [LINE_W-1:0] line_route_out0 [NUM_GROUPS];
   logic [LINE_W-1:0] line_enable [NUM_GROUPS];
   logic [LINE_W-1:0] line_pending [NUM_GROUPS];
   logic [LINE_W-1:0] line_prev_level [NUM_GROUPS];

   // Responses still owed by the DUT, oldest first
   rsp_type expected_responses [$];

   // Stimulus side copy of the last levels driven per group (out-of-range group too)
   logic [LINE_W-1:0] drive_levels [NUM_GROUPS+1];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int sample_count = 0;
   int write_count = 0;
   int read_count = 0;
   int other_count = 0;
   rsp_type oldest_expected;

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_failure(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic [LINE_W-1:0] masked_out1(input int g);
      return line_pending[g] & line_enable[g] & ~line_route_out0[g];
   endfunction

   function automatic logic [LINE_W-1:0] masked_out0(input int g);
      return line_pending[g] & line_enable[g] & line_route_out0[g];
   endfunction

   function automatic logic [LINE_W-1:0] summary_word();
      logic [LINE_W-1:0] s;
      s = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (masked_out1(g) != '0) s[g] = 1'b1;
         if (masked_out0(g) != '0) s[g + SUMMARY_OUT0_SHIFT] = 1'b1;
      end
      return s;
   endfunction

   function automatic void clear_controller_state();
      for (int g = 0; g < NUM_GROUPS; g++) begin
         line_edge_type[g]  = '0;
         line_low_active[g] = '0;
         line_route_out0[g] = '0;
         line_enable[g]     = '0;
         line_pending[g]    = '0;
         line_prev_level[g] = '0;
      end
   endfunction

   // Apply one request to the model state and return the response it produces
   function automatic rsp_type predict_response(input req_type item);
      rsp_type           res;
      int                g;
      logic              in_range;
      logic [LINE_W-1:0] active_now;
      logic [LINE_W-1:0] active_prev;
      res = '0;
      g = item.group_index;
      in_range = (g < NUM_GROUPS);
      case (item.opcode)
         OP_SAMPLE: begin
            if (in_range) begin
               active_now  = item.write_data ^ line_low_active[g];
               active_prev = line_prev_level[g] ^ line_low_active[g];
               // edge lines latch on inactive->active, level lines while active
               line_pending[g] |= (active_now & ~active_prev & line_edge_type[g])
                                | (active_now & ~line_edge_type[g]);
               line_prev_level[g] = item.write_data;
            end
         end
         OP_WRITE: begin
            if (in_range) begin
               case (item.reg_select)
                  REG_TYPE:     line_edge_type[g]  = item.write_data;
                  REG_POLARITY: line_low_active[g] = item.write_data;
                  REG_ROUTE:    line_route_out0[g] = item.write_data;
                  REG_ENABLE:   line_enable[g]     = item.write_data;
                  REG_CLEAR:    line_pending[g]   &= ~item.write_data;
                  default: ;
               endcase
            end
         end
         OP_READ: begin
            if (item.reg_select == REG_SUMMARY) begin
               res.read_data = summary_word();
            end else if (in_range) begin
               case (item.reg_select)
                  REG_TYPE:     res.read_data = line_edge_type[g];
                  REG_POLARITY: res.read_data = line_low_active[g];
                  REG_ROUTE:    res.read_data = line_route_out0[g];
                  REG_ENABLE:   res.read_data = line_enable[g];
                  REG_MASK_O1:  res.read_data = masked_out1(g);
                  REG_MASK_O0:  res.read_data = masked_out0(g);
                  default:      res.read_data = '0;
               endcase
            end
         end
         default: ;
      endcase
      // request outputs reflect state after the item
      for (int k = 0; k < NUM_GROUPS; k++) begin
         if (masked_out0(k) != '0) res.out0_request = 1'b1;
         if (masked_out1(k) != '0) res.out1_request = 1'b1;
      end
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input int grp,
                                        input logic [2:0] sel, input logic [LINE_W-1:0] data);
      req_type r;
      r.opcode      = op;
      r.group_index = grp[GROUP_IDX_W-1:0];
      r.reg_select  = sel;
      r.write_data  = data;
      return r;
   endfunction

   // Mix of corner words and random words
   function automatic logic [LINE_W-1:0] random_word();
      int pick;
      pick = $urandom_range(5);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      if (pick == 2) return LINE_W'(1) << $urandom_range(LINE_W-1);
      if (pick == 3) return $urandom & $urandom & $urandom;
      return $urandom;
   endfunction

   // Send one request transfer; prediction is made at the accepting edge
   task automatic send_item(input req_type item);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_responses.push_back(predict_response(item));
      requests_sent++;
      if (item.opcode == OP_SAMPLE && item.group_index < NUM_GROUPS) sample_count++;
      else if (item.opcode == OP_WRITE && item.group_index < NUM_GROUPS) write_count++;
      else if (item.opcode == OP_READ) read_count++;
      else other_count++;
   endtask

   // Stop sending and wait for every outstanding response, then a few more cycles
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response checker and receiver stall generation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            report_failure($sformatf("response transfer with none expected: %h", rsp_data));
         end else begin
            oldest_expected = expected_responses.pop_front();
            responses_checked++;
            if (rsp_data.read_data !== oldest_expected.read_data)
               report_failure($sformatf("read_data got %h want %h",
                                        rsp_data.read_data, oldest_expected.read_data));
            if (rsp_data.out0_request !== oldest_expected.out0_request)
               report_failure($sformatf("out0_request got %b want %b",
                                        rsp_data.out0_request, oldest_expected.out0_request));
            if (rsp_data.out1_request !== oldest_expected.out1_request)
               report_failure($sformatf("out1_request got %b want %b",
                                        rsp_data.out1_request, oldest_expected.out1_request));
         end
      end
      rsp_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   // Everything reads zero and all lines are masked after reset
   task automatic test_reset_values();
      send_item(make_req(OP_READ, 0, REG_SUMMARY, '0));
      send_item(make_req(OP_READ, 0, REG_TYPE, '1));
      send_item(make_req(OP_READ, NUM_GROUPS-1, REG_ENABLE, '0));
   endtask

   // Edge lines latch once per activation, level lines while active, polarity and routing
   task automatic test_edge_and_level();
      send_item(make_req(OP_WRITE, 0, REG_TYPE, 32'hFFFF_0000));
      send_item(make_req(OP_WRITE, 0, REG_POLARITY, 32'hF0F0_F0F0));
      send_item(make_req(OP_WRITE, 0, REG_ROUTE, 32'hAAAA_AAAA));
      send_item(make_req(OP_WRITE, 0, REG_ENABLE, 32'hFFFF_FFFF));
      send_item(make_req(OP_SAMPLE, 0, REG_TYPE, 32'h0000_0000));
      send_item(make_req(OP_SAMPLE, 0, REG_TYPE, 32'hFFFF_FFFF));
      send_item(make_req(OP_SAMPLE, 0, REG_TYPE, 32'hFFFF_FFFF));
      send_item(make_req(OP_READ, 0, REG_MASK_O1, '0));
      send_item(make_req(OP_READ, 0, REG_MASK_O0, '0));
      send_item(make_req(OP_READ, 0, REG_POLARITY, '0));
      // top group routed entirely to output 0
      send_item(make_req(OP_WRITE, NUM_GROUPS-1, REG_ROUTE, '1));
      send_item(make_req(OP_WRITE, NUM_GROUPS-1, REG_ENABLE, '1));
      send_item(make_req(OP_SAMPLE, NUM_GROUPS-1, REG_TYPE, 32'h8000_0001));
      send_item(make_req(OP_READ, 0, REG_SUMMARY, '0));
   endtask

   // Write-one-to-clear, read of clear, writes to read-only registers, masking
   task automatic test_clear_and_readonly();
      send_item(make_req(OP_WRITE, 0, REG_ENABLE, 32'h0000_FFFF));
      send_item(make_req(OP_READ, 0, REG_MASK_O1, '0));
      send_item(make_req(OP_WRITE, 0, REG_MASK_O1, '1));
      send_item(make_req(OP_WRITE, 0, REG_CLEAR, '1));
      send_item(make_req(OP_READ, 0, REG_CLEAR, '0));
   endtask

   // Group beyond the last one, and the unused opcode
   task automatic test_out_of_range();
      send_item(make_req(OP_WRITE, NUM_GROUPS, REG_TYPE, '1));
      send_item(make_req(OP_SAMPLE, NUM_GROUPS, REG_TYPE, '1));
      send_item(make_req(OP_READ, NUM_GROUPS, REG_TYPE, '0));
      send_item(make_req(OP_READ, NUM_GROUPS, REG_SUMMARY, '0));
      send_item(make_req(OP_UNUSED, 0, REG_ROUTE, '1));
   endtask

   // Mostly configure/sample/read/clear sequences on one group, some pure noise
   task automatic run_random_traffic(input int item_count);
      int                sent;
      int                g;
      int                pick;
      req_type           item;
      logic [LINE_W-1:0] lv;
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(99) < 15) begin
            item.opcode      = 2'($urandom_range(3));
            item.group_index = GROUP_IDX_W'($urandom_range(7));
            item.reg_select  = 3'($urandom_range(7));
            item.write_data  = $urandom;
            send_item(item);
            sent++;
         end else begin
            g = ($urandom_range(19) == 0) ? NUM_GROUPS : $urandom_range(NUM_GROUPS-1);
            if ($urandom_range(2) == 0) begin
               for (int sel = REG_TYPE; sel <= REG_ENABLE; sel++) begin
                  if ($urandom_range(1) == 1) begin
                     send_item(make_req(OP_WRITE, g, 3'(sel), random_word()));
                     sent++;
                  end
               end
            end
            repeat ($urandom_range(8, 2)) begin
               pick = $urandom_range(9);
               if (pick <= 5) begin
                  lv = ($urandom_range(3) == 0) ? random_word() : drive_levels[g] ^ random_word();
                  drive_levels[g] = lv;
                  item = make_req(OP_SAMPLE, g, REG_TYPE, lv);
               end else if (pick == 6) begin
                  item = make_req(OP_READ, g, $urandom_range(1) ? REG_MASK_O1 : REG_MASK_O0,
                                  $urandom);
               end else if (pick == 7) begin
                  item = make_req(OP_READ, g, REG_SUMMARY, $urandom);
               end else if (pick == 8) begin
                  item = make_req(OP_WRITE, g, REG_CLEAR, random_word());
               end else begin
                  item = make_req(OP_READ, g, 3'($urandom_range(7)), $urandom);
               end
               send_item(item);
               sent++;
            end
         end
      end
   endtask

   // Sender holds off until the pipeline is empty, then resumes
   task automatic test_sender_pause();
      sender_idle_pct    = 0;
      receiver_stall_pct = 50;
      run_random_traffic(40);
      wait_for_responses();
      run_random_traffic(40);
      wait_for_responses();
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      run_random_traffic(count);
      wait_for_responses();
   endtask

   initial begin
      clear_controller_state();
      for (int g = 0; g <= NUM_GROUPS; g++) drive_levels[g] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_edge_and_level();
      test_clear_and_readonly();
      test_out_of_range();
      wait_for_responses();

      test_sender_pause();
      test_random_phase(0, 0, 430);
      test_random_phase(67, 0, 430);
      test_random_phase(0, 67, 430);
      test_random_phase(24, 24, 430);

      $display("Run covered %0d request transfers: %0d samples, %0d writes, %0d reads, %0d no-ops.",
               requests_sent, sample_count, write_count, read_count, other_count);
      $display("Checked %0d response transfers across idle, sender-gap, stall and mixed phases.",
               responses_checked);
      if (error_count == 0) begin
         $display("grouped_interrupt_controller_top regression: pass");
      end else begin
         $display("grouped_interrupt_controller_top regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", expected_responses.size());
      $display("grouped_interrupt_controller_top regression: fail");
      $finish;
   end

endmodule
